@@ sv/lpht_pkg.sv @@
package lpht_pkg;

    localparam int SLOTS    = 64;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int KEY_W    = 8;
    localparam int TASK_W   = 8;
    localparam int KEY_BASE = 48;
    // (key - KEY_BASE) mod SLOTS, kept non-negative
    localparam int HOME_OFS = SLOTS - (KEY_BASE % SLOTS);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic       load;       // capture the incoming item
        logic       read;       // issue a slot read and advance the read pointer
        logic       step;       // count one compared slot
        logic       write;      // store key and task at the compared slot
        logic       res_load;   // latch the result
        logic [1:0] res_code;
        logic       res_take;   // take found task from the compared slot
        logic       push_out;   // move result into the output register
    } cmd_t;

    typedef struct packed {
        logic is_insert;
        logic key_zero;
        logic full;
        logic hit;
        logic last;
        logic out_free;
    } stat_t;

    function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
        logic [KEY_W+1:0] sum;
        sum = (KEY_W+2)'(key) + (KEY_W+2)'(HOME_OFS);
        return IDX_W'(sum % SLOTS);
    endfunction

endpackage

@@ sv/linear_probe_hash_table_unit.sv @@
// Open-addressing hash table with linear probing over 64 slots.
// Input channel (s_*): one command item per handshake. s_tuser carries the
// operation (insert or search), s_tdata the key and the task id.
// Result channel (m_*): exactly one item per command, in order. m_tuser
// carries the status (ok, table full, key not found), m_tdata the task id
// found by a search, zero otherwise.
// A command with key zero or an insert into a full table reads no slots.
// Otherwise the slot memory is read once per cycle along the probe path
// until a hit or the last slot; a search miss compares all 64 slots.
// One command is worked at a time; the next is accepted in the cycle after the
// result has moved into the output register, so a new item is not taken
// before the last one is through.
// A result waiting on m_tready does not block acceptance of the next item;
// that item's result is held inside until the output register frees.
// Reset (aresetn low, synchronous) marks every slot empty at once through a
// per-slot valid bit, clears the occupancy count and drops m_tvalid.
module linear_probe_hash_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key, [15:8] task_id
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] found_task
    output logic [1:0]  m_tuser    // [1:0] status
);

    lpht_pkg::cmd_t  cmd;
    lpht_pkg::stat_t stat;

    lpht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpht_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser[0]),
        .in_key     (s_tdata[7:0]),
        .in_task    (s_tdata[15:8]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_task   (m_tdata)
    );

endmodule

@@ sv/lpht_datapath.sv @@
module lpht_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lpht_pkg::cmd_t                      cmd,
    output lpht_pkg::stat_t                     stat,
    input  logic                                in_op,
    input  logic [lpht_pkg::KEY_W-1:0]          in_key,
    input  logic [lpht_pkg::TASK_W-1:0]         in_task,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_status,
    output logic [lpht_pkg::TASK_W-1:0]         out_task
);

    logic                               op_reg;
    logic [lpht_pkg::KEY_W-1:0]         key_reg;
    logic [lpht_pkg::TASK_W-1:0]        task_reg;
    logic [lpht_pkg::IDX_W-1:0]         rd_pos_reg, rd_pos_next;
    logic [lpht_pkg::IDX_W-1:0]         cmp_pos_reg;
    logic [lpht_pkg::CNT_W-1:0]         probes_reg;
    logic [lpht_pkg::CNT_W-1:0]         used_reg;
    logic [lpht_pkg::SLOTS-1:0]         valid_reg;
    logic [lpht_pkg::KEY_W-1:0]         key_mem_reg  [lpht_pkg::SLOTS];
    logic [lpht_pkg::TASK_W-1:0]        task_mem_reg [lpht_pkg::SLOTS];
    logic [lpht_pkg::KEY_W-1:0]         rd_key_reg;
    logic [lpht_pkg::TASK_W-1:0]        rd_task_reg;
    logic                               rd_vbit_reg;
    logic [lpht_pkg::KEY_W-1:0]         slot_key;
    logic [1:0]                         res_code_reg;
    logic [lpht_pkg::TASK_W-1:0]        res_task_reg;
    logic                               out_valid_reg;
    logic [1:0]                         out_status_reg;
    logic [lpht_pkg::TASK_W-1:0]        out_task_reg;

    // an unwritten slot reads as empty
    assign slot_key = rd_vbit_reg ? rd_key_reg : '0;

    always_comb begin
        if (cmd.load) begin
            rd_pos_next = lpht_pkg::home_slot(in_key);
        end else if (cmd.read) begin
            rd_pos_next = (rd_pos_reg == lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1)) ?
                          '0 : rd_pos_reg + 1'b1;
        end else begin
            rd_pos_next = rd_pos_reg;
        end
    end

    assign stat.is_insert = (op_reg == lpht_pkg::OP_INSERT);
    assign stat.key_zero  = (key_reg == '0);
    assign stat.full      = (used_reg == lpht_pkg::CNT_W'(lpht_pkg::SLOTS));
    assign stat.hit       = stat.is_insert ? (slot_key == '0) : (slot_key == key_reg);
    assign stat.last      = (probes_reg == lpht_pkg::CNT_W'(lpht_pkg::SLOTS - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            key_reg  <= in_key;
            task_reg <= in_task;
        end
        rd_pos_reg <= rd_pos_next;
        if (cmd.read) begin
            cmp_pos_reg <= rd_pos_reg;
            rd_key_reg  <= key_mem_reg[rd_pos_reg];
            rd_task_reg <= task_mem_reg[rd_pos_reg];
            rd_vbit_reg <= valid_reg[rd_pos_reg];
        end
        if (cmd.write) begin
            key_mem_reg[cmp_pos_reg]  <= key_reg;
            task_mem_reg[cmp_pos_reg] <= task_reg;
        end
        if (cmd.res_load) begin
            res_code_reg <= cmd.res_code;
            res_task_reg <= cmd.res_take ? rd_task_reg : '0;
        end
        if (cmd.push_out) begin
            out_status_reg <= res_code_reg;
            out_task_reg   <= res_task_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probes_reg    <= '0;
            used_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                probes_reg <= '0;
            end else if (cmd.step) begin
                probes_reg <= probes_reg + 1'b1;
            end
            if (cmd.write) begin
                valid_reg[cmp_pos_reg] <= 1'b1;
                used_reg               <= used_reg + 1'b1;
            end
            if (cmd.push_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_task   = out_task_reg;

endmodule

@@ sv/lpht_ctrl.sv @@
module lpht_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  lpht_pkg::stat_t  stat,
    output lpht_pkg::cmd_t   cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (stat.key_zero) begin
                    // key zero: insert is a no-op, search always misses
                    cmd.res_load = 1'b1;
                    cmd.res_code = stat.is_insert ? lpht_pkg::ST_OK : lpht_pkg::ST_MISS;
                    state_next   = S_FINISH;
                end else if (stat.is_insert && stat.full) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = lpht_pkg::ST_FULL;
                    state_next   = S_FINISH;
                end else begin
                    cmd.read   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.read = 1'b1;
                if (stat.hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = lpht_pkg::ST_OK;
                    cmd.res_take = !stat.is_insert;
                    cmd.write    = stat.is_insert;
                    state_next   = S_FINISH;
                end else if (stat.last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = stat.is_insert ? lpht_pkg::ST_FULL : lpht_pkg::ST_MISS;
                    state_next   = S_FINISH;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_FINISH: begin
                // hold until the output register can take the item
                if (stat.out_free) begin
                    cmd.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ test/lpht_reply_checker.sv @@
module lpht_reply_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key, [15:8] task_id
    input  logic [0:0]  s_tuser,   // [0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] found_task
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fail_count,
    output int          replies_owed
);

    typedef struct packed {
        logic [1:0]                  status;
        logic [lpht_pkg::TASK_W-1:0] found_task;
    } reply_t;

    reply_t                      reply_queue[$];
    logic [lpht_pkg::KEY_W-1:0]  table_key [lpht_pkg::SLOTS];
    logic [lpht_pkg::TASK_W-1:0] table_tid [lpht_pkg::SLOTS];
    int                          occupied;
    int                          fails = 0;
    int                          owed  = 0;

    assign fail_count   = fails;
    assign replies_owed = owed;

    function automatic int probe_start(input logic [lpht_pkg::KEY_W-1:0] key);
        return (int'(key) + lpht_pkg::SLOTS * lpht_pkg::KEY_BASE - lpht_pkg::KEY_BASE)
               % lpht_pkg::SLOTS;
    endfunction

    // Apply one command to the table copy and return the reply it earns.
    function automatic reply_t run_command(input logic op,
                                           input logic [lpht_pkg::KEY_W-1:0] key,
                                           input logic [lpht_pkg::TASK_W-1:0] tid);
        reply_t r;
        int     pos;
        r.status     = lpht_pkg::ST_OK;
        r.found_task = '0;
        pos          = probe_start(key);
        if (op == lpht_pkg::OP_INSERT) begin
            if (key != 0) begin
                r.status = lpht_pkg::ST_FULL;
                if (occupied < lpht_pkg::SLOTS) begin
                    for (int n = 0; n < lpht_pkg::SLOTS; n++) begin
                        if (table_key[pos] == 0) begin
                            table_key[pos] = key;
                            table_tid[pos] = tid;
                            occupied++;
                            r.status = lpht_pkg::ST_OK;
                            break;
                        end
                        pos = (pos + 1) % lpht_pkg::SLOTS;
                    end
                end
            end
        end else begin
            r.status = lpht_pkg::ST_MISS;
            if (key != 0) begin
                for (int n = 0; n < lpht_pkg::SLOTS; n++) begin
                    if (table_key[pos] == key) begin
                        r.status     = lpht_pkg::ST_OK;
                        r.found_task = table_tid[pos];
                        break;
                    end
                    pos = (pos + 1) % lpht_pkg::SLOTS;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
                table_key[i] = '0;
                table_tid[i] = '0;
            end
            occupied = 0;
            reply_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_queue.size() == 0) begin
                    $display("%0t: unexpected reply status=%0d found_task=%0d",
                             $time, m_tuser, m_tdata);
                    fails++;
                end else begin
                    want = reply_queue.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_tuser);
                        fails++;
                    end
                    if (m_tdata !== want.found_task) begin
                        $display("%0t: found_task mismatch: expected %0d, actual %0d",
                                 $time, want.found_task, m_tdata);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                reply_queue.push_back(run_command(s_tuser[0], s_tdata[7:0], s_tdata[15:8]));
        end
        owed = reply_queue.size();
    end

endmodule

@@ test/linear_probe_hash_table_unit_tb.sv @@
module linear_probe_hash_table_unit_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 400;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int replies_owed;
    int cycles = 0;

    // stimulus-side bookkeeping
    int         burst_left = 0;
    bit         no_gaps    = 1'b0;
    int         filled     = 0;
    logic [7:0] known_keys[$];

    linear_probe_hash_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lpht_reply_checker reply_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver backpressure: switch between four ready patterns at random.
    int ready_mode = 0;
    int ready_tick = 0;
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 256 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (ready_tick % 4 == 0);
            default: m_tready <= (ready_tick % 32 >= 20);
        endcase
    end

    task automatic send_command(input logic op, input logic [7:0] key, input logic [7:0] tid);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tid, key};
        do @(posedge aclk); while (!s_tready);
        if (op == lpht_pkg::OP_INSERT && key != 0) begin
            if (filled < lpht_pkg::SLOTS)
                filled++;
            known_keys.push_back(key);
        end
    endtask

    // keys whose home slots bunch up near slot zero
    function automatic logic [7:0] clustered_key();
        return 8'(lpht_pkg::KEY_BASE + $urandom_range(0, 5)
                  + lpht_pkg::SLOTS * $urandom_range(0, 3));
    endfunction

    initial begin
        logic       op;
        logic [7:0] key;
        int         pick;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: full-lap miss, zero key on both operations
        send_command(lpht_pkg::OP_SEARCH, 8'd48,  8'd0);
        send_command(lpht_pkg::OP_SEARCH, 8'd0,   8'd0);
        send_command(lpht_pkg::OP_INSERT, 8'd0,   8'h55);
        // home slot zero, last slot, wrap past the end
        send_command(lpht_pkg::OP_INSERT, 8'd48,  8'hAA);
        send_command(lpht_pkg::OP_INSERT, 8'd47,  8'h01);
        send_command(lpht_pkg::OP_INSERT, 8'd111, 8'hFF);
        send_command(lpht_pkg::OP_SEARCH, 8'd111, 8'h00);
        // duplicate key: search returns the earlier copy
        send_command(lpht_pkg::OP_INSERT, 8'd48,  8'h33);
        send_command(lpht_pkg::OP_SEARCH, 8'd48,  8'hFF);
        // largest key, and a key below the base
        send_command(lpht_pkg::OP_INSERT, 8'd255, 8'h00);
        send_command(lpht_pkg::OP_INSERT, 8'd1,   8'h80);
        send_command(lpht_pkg::OP_SEARCH, 8'd1,   8'h12);
        send_command(lpht_pkg::OP_SEARCH, 8'd255, 8'h00);
        send_command(lpht_pkg::OP_SEARCH, 8'd47,  8'hFF);
        send_command(lpht_pkg::OP_SEARCH, 8'd2,   8'h00);
        send_command(lpht_pkg::OP_INSERT, 8'd112, 8'h7E);
        send_command(lpht_pkg::OP_SEARCH, 8'd112, 8'h81);
        send_command(lpht_pkg::OP_SEARCH, 8'd0,   8'hFF);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if (filled < lpht_pkg::SLOTS)
                op = ($urandom_range(0, 99) < 45) ? lpht_pkg::OP_INSERT
                                                  : lpht_pkg::OP_SEARCH;
            else
                op = ($urandom_range(0, 99) < 15) ? lpht_pkg::OP_INSERT
                                                  : lpht_pkg::OP_SEARCH;
            pick = $urandom_range(0, 99);
            if (op == lpht_pkg::OP_INSERT) begin
                if (pick < 5)
                    key = 8'd0;
                else if (pick < 15 && known_keys.size() > 0)
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else if (pick < 40)
                    key = clustered_key();
                else
                    key = 8'($urandom_range(1, 255));
            end else begin
                if (pick < 5)
                    key = 8'd0;
                else if (pick < 60 && known_keys.size() > 0)
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else if (pick < 75)
                    key = clustered_key();
                else
                    key = 8'($urandom_range(0, 255));
            end
            send_command(op, key, 8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        // let the checker register the last accepted item first
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (fail_count == 0 && replies_owed == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/lpht_pkg.sv
sv/lpht_datapath.sv
sv/lpht_ctrl.sv
sv/linear_probe_hash_table_unit.sv
test/lpht_reply_checker.sv
test/linear_probe_hash_table_unit_tb.sv
